>>> rtl/o3wo_pkg.sv
// o3wo_pkg: shared types, fixed-point constants and the microcode ROM of the
// three-wheel omni odometry block. No dependencies.
package o3wo_pkg;

    // Fixed-point constants
    localparam logic [32:0] KX_Q24  = 33'd97606;    // pi/(180*3) in Q24
    localparam logic [32:0] KY_Q24  = 33'd169063;   // pi/(180*1.732) in Q24
    localparam logic [32:0] ANG_Q30 = 33'd292817;   // pi/11520 in Q30
    localparam logic [15:0] FULL_TURN = 16'd23040;
    localparam logic [14:0] QUARTER_1 = 15'd5760;
    localparam logic [14:0] QUARTER_2 = 15'd11520;
    localparam logic [14:0] QUARTER_3 = 15'd17280;

    // Datapath widths fixed by the field widths
    localparam int MUL_W  = 33;     // signed multiplier operand
    localparam int PROD_W = 66;     // signed product
    localparam int DS_W   = 18;     // wheel angle sums
    localparam int MV_W   = 27;     // wheel sum times radius
    localparam int BX_W   = 28;     // body move in Q8
    localparam int SUM_W  = 34;     // series sum in Q30
    localparam int REM_W  = 13;     // heading remainder in a quadrant
    localparam int PC_W   = 6;

    localparam logic [2:0] K_LAST = 3'd7;

    // Multiplier operand selects
    localparam logic [3:0] MUL_NONE = 4'd0;
    localparam logic [3:0] MUL_DXR  = 4'd1;
    localparam logic [3:0] MUL_DYR  = 4'd2;
    localparam logic [3:0] MUL_MVKX = 4'd3;
    localparam logic [3:0] MUL_MVKY = 4'd4;
    localparam logic [3:0] MUL_ANG  = 4'd5;
    localparam logic [3:0] MUL_TX   = 4'd6;
    localparam logic [3:0] MUL_TM   = 4'd7;
    localparam logic [3:0] MUL_QD   = 4'd8;
    localparam logic [3:0] MUL_BXC  = 4'd9;
    localparam logic [3:0] MUL_BYS  = 4'd10;
    localparam logic [3:0] MUL_BXS  = 4'd11;
    localparam logic [3:0] MUL_BYC  = 4'd12;

    // Product write-back operations
    localparam logic [3:0] WB_NONE  = 4'd0;
    localparam logic [3:0] WB_MV    = 4'd1;
    localparam logic [3:0] WB_BX    = 4'd2;
    localparam logic [3:0] WB_BY    = 4'd3;
    localparam logic [3:0] WB_XINIT = 4'd4;
    localparam logic [3:0] WB_T     = 4'd5;
    localparam logic [3:0] WB_Q     = 4'd6;
    localparam logic [3:0] WB_FIX   = 4'd7;
    localparam logic [3:0] WB_WLOAD = 4'd8;
    localparam logic [3:0] WB_WSUB  = 4'd9;
    localparam logic [3:0] WB_WADD  = 4'd10;

    // Other actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_COS_INIT = 3'd1;
    localparam logic [2:0] ACT_TRIG     = 3'd2;
    localparam logic [2:0] ACT_XADD     = 3'd3;
    localparam logic [2:0] ACT_YADD     = 3'd4;
    localparam logic [2:0] ACT_DONE     = 3'd5;

    // Program addresses
    localparam logic [PC_W-1:0] PC_START   = 6'd0;
    localparam logic [PC_W-1:0] PC_SIN_TOP = 6'd8;
    localparam logic [PC_W-1:0] PC_COS_TOP = 6'd17;
    localparam logic [PC_W-1:0] PC_DONE    = 6'd33;

    typedef struct packed {
        logic [3:0]      mul_sel;
        logic [3:0]      wb_sel;
        logic [2:0]      act_sel;
        logic            loop;
        logic [PC_W-1:0] target;
    } ucode_t;

    // Series divisors: sin uses (2k)(2k+1), cos uses (2k-1)(2k)
    function automatic logic [7:0] series_div(input logic cos_pass, input logic [2:0] k);
        logic [7:0] d;
        begin
            d = 8'd6;
            case ({cos_pass, k})
                4'b0_001: d = 8'd6;
                4'b0_010: d = 8'd20;
                4'b0_011: d = 8'd42;
                4'b0_100: d = 8'd72;
                4'b0_101: d = 8'd110;
                4'b0_110: d = 8'd156;
                4'b0_111: d = 8'd210;
                4'b1_001: d = 8'd2;
                4'b1_010: d = 8'd12;
                4'b1_011: d = 8'd30;
                4'b1_100: d = 8'd56;
                4'b1_101: d = 8'd90;
                4'b1_110: d = 8'd132;
                4'b1_111: d = 8'd182;
                default:  d = 8'd6;
            endcase
            return d;
        end
    endfunction

    // floor(2^32 / divisor), matching series_div
    function automatic logic [31:0] series_recip(input logic cos_pass, input logic [2:0] k);
        logic [31:0] m;
        begin
            m = 32'd715827882;
            case ({cos_pass, k})
                4'b0_001: m = 32'd715827882;
                4'b0_010: m = 32'd214748364;
                4'b0_011: m = 32'd102261126;
                4'b0_100: m = 32'd59652323;
                4'b0_101: m = 32'd39045157;
                4'b0_110: m = 32'd27531841;
                4'b0_111: m = 32'd20452225;
                4'b1_001: m = 32'd2147483648;
                4'b1_010: m = 32'd357913941;
                4'b1_011: m = 32'd143165576;
                4'b1_100: m = 32'd76695844;
                4'b1_101: m = 32'd47721858;
                4'b1_110: m = 32'd32537631;
                4'b1_111: m = 32'd23598721;
                default:  m = 32'd715827882;
            endcase
            return m;
        end
    endfunction

    // Microcode: one control word per step. A write-back consumes the
    // product started by the previous step.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        begin
            w = '{MUL_NONE, WB_NONE, ACT_NONE, 1'b0, PC_START};
            case (pc)
                6'd0:  w.mul_sel = MUL_DXR;
                6'd1:  w.wb_sel  = WB_MV;
                6'd2:  w.mul_sel = MUL_MVKX;
                6'd3:
                begin
                    w.wb_sel  = WB_BX;
                    w.mul_sel = MUL_DYR;
                end
                6'd4:  w.wb_sel  = WB_MV;
                6'd5:  w.mul_sel = MUL_MVKY;
                6'd6:
                begin
                    w.wb_sel  = WB_BY;
                    w.mul_sel = MUL_ANG;
                end
                6'd7:  w.wb_sel  = WB_XINIT;
                // sine series body
                6'd8:  w.mul_sel = MUL_TX;
                6'd9:  w.wb_sel  = WB_T;
                6'd10: w.mul_sel = MUL_TX;
                6'd11: w.wb_sel  = WB_T;
                6'd12: w.mul_sel = MUL_TM;
                6'd13: w.wb_sel  = WB_Q;
                6'd14: w.mul_sel = MUL_QD;
                6'd15:
                begin
                    w.wb_sel = WB_FIX;
                    w.loop   = 1'b1;
                    w.target = PC_SIN_TOP;
                end
                6'd16: w.act_sel = ACT_COS_INIT;
                // cosine series body
                6'd17: w.mul_sel = MUL_TX;
                6'd18: w.wb_sel  = WB_T;
                6'd19: w.mul_sel = MUL_TX;
                6'd20: w.wb_sel  = WB_T;
                6'd21: w.mul_sel = MUL_TM;
                6'd22: w.wb_sel  = WB_Q;
                6'd23: w.mul_sel = MUL_QD;
                6'd24:
                begin
                    w.wb_sel = WB_FIX;
                    w.loop   = 1'b1;
                    w.target = PC_COS_TOP;
                end
                6'd25: w.act_sel = ACT_TRIG;
                // rotate body move into world frame
                6'd26: w.mul_sel = MUL_BXC;
                6'd27:
                begin
                    w.wb_sel  = WB_WLOAD;
                    w.mul_sel = MUL_BYS;
                end
                6'd28: w.wb_sel  = WB_WSUB;
                6'd29:
                begin
                    w.act_sel = ACT_XADD;
                    w.mul_sel = MUL_BXS;
                end
                6'd30:
                begin
                    w.wb_sel  = WB_WLOAD;
                    w.mul_sel = MUL_BYC;
                end
                6'd31: w.wb_sel  = WB_WADD;
                6'd32: w.act_sel = ACT_YADD;
                6'd33: w.act_sel = ACT_DONE;
                default: w.act_sel = ACT_DONE;
            endcase
            return w;
        end
    endfunction

endpackage

>>> rtl/omni3_wheel_odometry.sv
// omni3_wheel_odometry: dead-reckoning odometry for a three-wheel omni base,
// a microcoded sequencer around one 33x33 signed multiplier. Uses o3wo_pkg.
//
// Input channel (in_valid/in_ready) takes one request: three wheel angle
// changes, a heading and wheels_ready. Output channel (out_valid/out_ready)
// returns one result per request: the world x and y totals after it and
// updated (equal to wheels_ready). The cfg channel writes wheel_radius and
// is always ready; write it only while the block is idle.
// A request with wheels_ready set walks a 34-step program with two 7-term
// Taylor loops, 8 steps a term. A request without it skips to the last
// step and returns the unchanged totals. The single shared multiplier
// serialises the work; a step may retire the product of the step before.
// One request is in work at a time; in_ready is high whenever the sequencer is
// idle, also while a finished result waits in the output register.
// Reset clears both totals, sets wheel_radius to 50 and empties the output.
// If the receiver stalls, the next request runs to its last step and holds
// there until the output register frees up.
module omni3_wheel_odometry #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         wheel_radius,
    // request channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               wheels_ready,
    input  logic signed [15:0] wheel_turn_1,
    input  logic signed [15:0] wheel_turn_2,
    input  logic signed [15:0] wheel_turn_3,
    input  logic signed [14:0] heading,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] x_position,
    output logic signed [31:0] y_position,
    output logic               updated
);

    localparam int TRIG_W = TRIG_FRAC_BITS + 2;
    localparam int W_W    = TRIG_FRAC_BITS + 30;
    localparam int SHR_W  = 8 + TRIG_FRAC_BITS;
    localparam logic [o3wo_pkg::SUM_W:0] TRIG_HALF =
        {{o3wo_pkg::SUM_W{1'b0}}, 1'b1} << (29 - TRIG_FRAC_BITS);
    localparam logic signed [o3wo_pkg::SUM_W:0] TRIG_ONE =
        {{o3wo_pkg::SUM_W{1'b0}}, 1'b1} << TRIG_FRAC_BITS;
    localparam logic [W_W:0] W_HALF = {{W_W{1'b0}}, 1'b1} << (SHR_W - 1);
    localparam logic signed [o3wo_pkg::SUM_W-1:0] Q30_ONE =
        {{(o3wo_pkg::SUM_W-1){1'b0}}, 1'b1} << 30;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Control state
    logic                       state_reg;
    logic [o3wo_pkg::PC_W-1:0]  pc_reg;
    logic                       out_valid_reg;
    logic [7:0]                 radius_reg;
    logic signed [31:0]         x_total_reg;
    logic signed [31:0]         y_total_reg;

    // Datapath registers
    logic signed [o3wo_pkg::DS_W-1:0]   dxs_reg;
    logic signed [o3wo_pkg::DS_W-1:0]   dys_reg;
    logic [o3wo_pkg::REM_W-1:0]         rem_reg;
    logic [1:0]                         quad_reg;
    logic                               upd_reg;
    logic signed [o3wo_pkg::PROD_W-1:0] prod_reg;
    logic signed [o3wo_pkg::MV_W-1:0]   mv_reg;
    logic signed [o3wo_pkg::BX_W-1:0]   bx_reg;
    logic signed [o3wo_pkg::BX_W-1:0]   by_reg;
    logic [30:0]                        x_reg;
    logic [31:0]                        t_reg;
    logic [31:0]                        q_reg;
    logic signed [o3wo_pkg::SUM_W-1:0]  sum_reg;
    logic [2:0]                         k_reg;
    logic signed [TRIG_W-1:0]           sin_reg;
    logic signed [TRIG_W-1:0]           cos_reg;
    logic signed [W_W-1:0]              w_reg;
    logic signed [31:0]                 x_out_reg;
    logic signed [31:0]                 y_out_reg;
    logic                               upd_out_reg;

    // Combinational signals
    o3wo_pkg::ucode_t                   uw;
    logic                               in_fire;
    logic                               out_free;
    logic                               cos_pass;
    logic [7:0]                         div_k;
    logic [31:0]                        recip_k;
    logic signed [o3wo_pkg::MUL_W-1:0]  mul_a;
    logic signed [o3wo_pkg::MUL_W-1:0]  mul_b;
    logic [15:0]                        hm_wide;
    logic [14:0]                        hm;
    logic [1:0]                         quad_next;
    logic [14:0]                        rem_next;
    logic signed [o3wo_pkg::PROD_W-1:0] prod_rnd;
    logic [32:0]                        fix_rem;
    logic [31:0]                        q_next;
    logic signed [o3wo_pkg::SUM_W-1:0]  sum_next;
    logic signed [o3wo_pkg::SUM_W:0]    trig_rnd;
    logic signed [o3wo_pkg::SUM_W:0]    trig_shr;
    logic signed [TRIG_W-1:0]           trig_val;
    logic signed [W_W:0]                w_rnd;
    logic signed [W_W:0]                w_shr;
    logic [32:0]                        tot_sum;
    logic signed [31:0]                 tot_sel;
    logic signed [31:0]                 tot_next;

    assign uw        = o3wo_pkg::ucode_rom(pc_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign cos_pass  = (pc_reg >= o3wo_pkg::PC_COS_TOP);
    assign div_k     = o3wo_pkg::series_div(cos_pass, k_reg);
    assign recip_k   = o3wo_pkg::series_recip(cos_pass, k_reg);

    assign out_valid  = out_valid_reg;
    assign x_position = x_out_reg;
    assign y_position = y_out_reg;
    assign updated    = upd_out_reg;

    // Fold heading into one turn, then split into quadrant and remainder
    always_comb
    begin
        hm_wide = {heading[14], heading} + (heading[14] ? o3wo_pkg::FULL_TURN : 16'd0);
        hm      = hm_wide[14:0];
        if (hm >= o3wo_pkg::QUARTER_3)
        begin
            quad_next = 2'd3;
            rem_next  = hm - o3wo_pkg::QUARTER_3;
        end
        else if (hm >= o3wo_pkg::QUARTER_2)
        begin
            quad_next = 2'd2;
            rem_next  = hm - o3wo_pkg::QUARTER_2;
        end
        else if (hm >= o3wo_pkg::QUARTER_1)
        begin
            quad_next = 2'd1;
            rem_next  = hm - o3wo_pkg::QUARTER_1;
        end
        else
        begin
            quad_next = 2'd0;
            rem_next  = hm;
        end
    end

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (uw.mul_sel)
            o3wo_pkg::MUL_DXR:
            begin
                mul_a = o3wo_pkg::MUL_W'(dxs_reg);
                mul_b = o3wo_pkg::MUL_W'(radius_reg);
            end
            o3wo_pkg::MUL_DYR:
            begin
                mul_a = o3wo_pkg::MUL_W'(dys_reg);
                mul_b = o3wo_pkg::MUL_W'(radius_reg);
            end
            o3wo_pkg::MUL_MVKX:
            begin
                mul_a = o3wo_pkg::MUL_W'(mv_reg);
                mul_b = o3wo_pkg::KX_Q24;
            end
            o3wo_pkg::MUL_MVKY:
            begin
                mul_a = o3wo_pkg::MUL_W'(mv_reg);
                mul_b = o3wo_pkg::KY_Q24;
            end
            o3wo_pkg::MUL_ANG:
            begin
                mul_a = o3wo_pkg::MUL_W'(rem_reg);
                mul_b = o3wo_pkg::ANG_Q30;
            end
            o3wo_pkg::MUL_TX:
            begin
                mul_a = o3wo_pkg::MUL_W'(t_reg);
                mul_b = o3wo_pkg::MUL_W'(x_reg);
            end
            o3wo_pkg::MUL_TM:
            begin
                mul_a = o3wo_pkg::MUL_W'(t_reg);
                mul_b = o3wo_pkg::MUL_W'(recip_k);
            end
            o3wo_pkg::MUL_QD:
            begin
                mul_a = o3wo_pkg::MUL_W'(q_reg);
                mul_b = o3wo_pkg::MUL_W'(div_k);
            end
            o3wo_pkg::MUL_BXC:
            begin
                mul_a = o3wo_pkg::MUL_W'(bx_reg);
                mul_b = o3wo_pkg::MUL_W'(cos_reg);
            end
            o3wo_pkg::MUL_BYS:
            begin
                mul_a = o3wo_pkg::MUL_W'(by_reg);
                mul_b = o3wo_pkg::MUL_W'(sin_reg);
            end
            o3wo_pkg::MUL_BXS:
            begin
                mul_a = o3wo_pkg::MUL_W'(bx_reg);
                mul_b = o3wo_pkg::MUL_W'(sin_reg);
            end
            o3wo_pkg::MUL_BYC:
            begin
                mul_a = o3wo_pkg::MUL_W'(by_reg);
                mul_b = o3wo_pkg::MUL_W'(cos_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round the body move product from Q24 to Q8
    assign prod_rnd = prod_reg + o3wo_pkg::PROD_W'(32768);

    // Correct the reciprocal quotient by at most one and fold the term in
    always_comb
    begin
        fix_rem  = {1'b0, t_reg} - prod_reg[32:0];
        q_next   = q_reg + ((fix_rem >= {25'd0, div_k}) ? 32'd1 : 32'd0);
        sum_next = k_reg[0] ? (sum_reg - o3wo_pkg::SUM_W'(q_next))
                            : (sum_reg + o3wo_pkg::SUM_W'(q_next));
    end

    // Round the Q30 series sum to the trig format and clamp to 0..1
    always_comb
    begin
        trig_rnd = {sum_reg[o3wo_pkg::SUM_W-1], sum_reg} + signed'(TRIG_HALF);
        trig_shr = trig_rnd >>> (30 - TRIG_FRAC_BITS);
        if (trig_shr[o3wo_pkg::SUM_W])
            trig_val = '0;
        else if (trig_shr > TRIG_ONE)
            trig_val = TRIG_ONE[TRIG_W-1:0];
        else
            trig_val = trig_shr[TRIG_W-1:0];
    end

    // Round the world move from Q(8+TRIG_FRAC_BITS) to whole units and add with saturation
    always_comb
    begin
        w_rnd   = {w_reg[W_W-1], w_reg} + signed'(W_HALF);
        w_shr   = w_rnd >>> SHR_W;
        tot_sel = (uw.act_sel == o3wo_pkg::ACT_YADD) ? y_total_reg : x_total_reg;
        tot_sum = {tot_sel[31], tot_sel} + w_shr[32:0];
        if (tot_sum[32] != tot_sum[31])
            tot_next = tot_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            tot_next = tot_sum[31:0];
    end

    // Sequencer, totals and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= o3wo_pkg::PC_START;
            out_valid_reg <= 1'b0;
            radius_reg    <= 8'd50;
            x_total_reg   <= '0;
            y_total_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radius_reg <= wheel_radius;

            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            if (in_fire)
            begin
                state_reg <= ST_RUN;
                pc_reg    <= wheels_ready ? o3wo_pkg::PC_START : o3wo_pkg::PC_DONE;
            end
            else if (state_reg == ST_RUN)
            begin
                if (uw.act_sel == o3wo_pkg::ACT_DONE)
                begin
                    // hold on the last step until the output register frees
                    if (out_free)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                else if (uw.loop && (k_reg != o3wo_pkg::K_LAST))
                    pc_reg <= uw.target;
                else
                    pc_reg <= pc_reg + 1'b1;

                if (uw.act_sel == o3wo_pkg::ACT_XADD)
                    x_total_reg <= tot_next;
                if (uw.act_sel == o3wo_pkg::ACT_YADD)
                    y_total_reg <= tot_next;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dxs_reg  <= o3wo_pkg::DS_W'(wheel_turn_1) + o3wo_pkg::DS_W'(wheel_turn_2)
                        - (o3wo_pkg::DS_W'(wheel_turn_3) <<< 1);
            dys_reg  <= o3wo_pkg::DS_W'(wheel_turn_2) - o3wo_pkg::DS_W'(wheel_turn_1);
            rem_reg  <= rem_next[o3wo_pkg::REM_W-1:0];
            quad_reg <= quad_next;
            upd_reg  <= wheels_ready;
        end

        if (state_reg == ST_RUN)
        begin
            if (uw.mul_sel != o3wo_pkg::MUL_NONE)
                prod_reg <= mul_a * mul_b;

            // retire the product of the previous step
            case (uw.wb_sel)
                o3wo_pkg::WB_MV:    mv_reg <= prod_reg[o3wo_pkg::MV_W-1:0];
                o3wo_pkg::WB_BX:    bx_reg <= prod_rnd[16 +: o3wo_pkg::BX_W];
                o3wo_pkg::WB_BY:    by_reg <= prod_rnd[16 +: o3wo_pkg::BX_W];
                o3wo_pkg::WB_XINIT:
                begin
                    x_reg   <= prod_reg[30:0];
                    t_reg   <= {1'b0, prod_reg[30:0]};
                    sum_reg <= o3wo_pkg::SUM_W'(prod_reg[30:0]);
                    k_reg   <= 3'd1;
                end
                o3wo_pkg::WB_T:     t_reg <= prod_reg[61:30];
                o3wo_pkg::WB_Q:     q_reg <= prod_reg[63:32];
                o3wo_pkg::WB_FIX:
                begin
                    t_reg   <= q_next;
                    sum_reg <= sum_next;
                    k_reg   <= k_reg + 3'd1;
                end
                o3wo_pkg::WB_WLOAD: w_reg <= prod_reg[W_W-1:0];
                o3wo_pkg::WB_WSUB:  w_reg <= w_reg - prod_reg[W_W-1:0];
                o3wo_pkg::WB_WADD:  w_reg <= w_reg + prod_reg[W_W-1:0];
                default:            ;
            endcase

            case (uw.act_sel)
                o3wo_pkg::ACT_COS_INIT:
                begin
                    sin_reg <= trig_val;
                    sum_reg <= Q30_ONE;
                    t_reg   <= 32'h4000_0000;
                    k_reg   <= 3'd1;
                end
                o3wo_pkg::ACT_TRIG:
                begin
                    // sin_reg holds the first-quadrant sine, trig_val the cosine
                    case (quad_reg)
                        2'd0:
                        begin
                            cos_reg <= trig_val;
                        end
                        2'd1:
                        begin
                            sin_reg <= trig_val;
                            cos_reg <= -sin_reg;
                        end
                        2'd2:
                        begin
                            sin_reg <= -sin_reg;
                            cos_reg <= -trig_val;
                        end
                        default:
                        begin
                            sin_reg <= -trig_val;
                            cos_reg <= sin_reg;
                        end
                    endcase
                end
                o3wo_pkg::ACT_DONE:
                begin
                    if (out_free)
                    begin
                        x_out_reg   <= x_total_reg;
                        y_out_reg   <= y_total_reg;
                        upd_out_reg <= upd_reg;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> dv/odometry_checker.sv
// odometry_checker: watches the config, request and result channels of
// omni3_wheel_odometry, predicts the world position totals and compares them.
// Standalone module, no package dependencies.
module odometry_checker #(
    parameter int TRIG_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         wheel_radius,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               wheels_ready,
    input  logic signed [15:0] wheel_turn_1,
    input  logic signed [15:0] wheel_turn_2,
    input  logic signed [15:0] wheel_turn_3,
    input  logic signed [14:0] heading,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] x_position,
    input  logic signed [31:0] y_position,
    input  logic               updated,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen,
    output int                 updates_seen,
    output int                 limit_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point gains: pi/(180*3), pi/(180*1.732) in Q24, pi/11520 in Q30
    localparam longint BODY_X_GAIN = 97606;
    localparam longint BODY_Y_GAIN = 169063;
    localparam longint unsigned ANGLE_STEP_Q30 = 292817;
    localparam int ONE_TURN = 23040;
    localparam int QUARTER = 5760;
    localparam int MAX_REPORTS = 10;
    localparam int POS_MAX = 32'sh7FFF_FFFF;
    localparam int POS_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               upd;
    } odo_result_t;

    logic [7:0]  radius_setting;
    int          x_sum;
    int          y_sum;
    odo_result_t expected_positions[$];

    initial
    begin
        fail_count   = 0;
        results_seen = 0;
        updates_seen = 0;
        limit_hits   = 0;
    end

    // Add half an LSB, then floor shift
    function automatic longint round_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // Round a Q30 series sum to the trig format and clamp to 0..1
    function automatic longint trig_clamp(input longint v30);
        longint v;
        v = round_shift(v30, 30 - TRIG_FRAC_BITS);
        if (v < 0)
            v = 0;
        if (v > (longint'(1) << TRIG_FRAC_BITS))
            v = longint'(1) << TRIG_FRAC_BITS;
        return v;
    endfunction

    function automatic int clamp_add(input int total, input longint inc);
        longint v;
        v = longint'(total) + inc;
        if (v > longint'(POS_MAX))
            v = POS_MAX;
        if (v < longint'(POS_MIN))
            v = POS_MIN;
        return int'(v);
    endfunction

    // Sine and cosine of a heading in 0..23039 from truncated Taylor series
    task automatic heading_sin_cos(input int hm, output longint sn, output longint cs);
        longint unsigned ang;
        longint unsigned term;
        longint          s_acc;
        longint          c_acc;
        longint          s_q;
        longint          c_q;
        int              quad;
        quad  = hm / QUARTER;
        ang   = longint'(hm % QUARTER) * ANGLE_STEP_Q30;
        term  = ang;
        s_acc = longint'(ang);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                s_acc -= longint'(term);
            else
                s_acc += longint'(term);
        end
        term  = longint'(1) << 30;
        c_acc = longint'(1) << 30;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
                c_acc -= longint'(term);
            else
                c_acc += longint'(term);
        end
        s_q = trig_clamp(s_acc);
        c_q = trig_clamp(c_acc);
        // apply the quadrant signs
        case (quad)
            0:
            begin
                sn = s_q;
                cs = c_q;
            end
            1:
            begin
                sn = c_q;
                cs = -s_q;
            end
            2:
            begin
                sn = -s_q;
                cs = -c_q;
            end
            default:
            begin
                sn = -c_q;
                cs = s_q;
            end
        endcase
    endtask

    // Advance the totals by one request and return the expected result
    task automatic dead_reckon(input logic ready_in, input logic signed [15:0] t1,
                               input logic signed [15:0] t2, input logic signed [15:0] t3,
                               input logic signed [14:0] hdg, output odo_result_t res);
        longint p1;
        longint p2;
        longint p3;
        longint bx8;
        longint by8;
        longint sn;
        longint cs;
        longint wx;
        longint wy;
        int     h;
        if (ready_in)
        begin
            p1 = longint'(t1) * longint'(radius_setting);
            p2 = longint'(t2) * longint'(radius_setting);
            p3 = longint'(t3) * longint'(radius_setting);
            h  = hdg;
            if (h < 0)
                h += ONE_TURN;
            bx8 = round_shift((p1 + p2 - 2 * p3) * BODY_X_GAIN, 16);
            by8 = round_shift((p2 - p1) * BODY_Y_GAIN, 16);
            heading_sin_cos(h, sn, cs);
            wx = bx8 * cs - by8 * sn;
            wy = bx8 * sn + by8 * cs;
            x_sum = clamp_add(x_sum, round_shift(wx, 8 + TRIG_FRAC_BITS));
            y_sum = clamp_add(y_sum, round_shift(wy, 8 + TRIG_FRAC_BITS));
        end
        res.x   = x_sum;
        res.y   = y_sum;
        res.upd = ready_in;
    endtask

    // Track config, predict each request, check each result against the oldest
    always @(posedge clk or negedge rst_n)
    begin : watch
        odo_result_t want;
        odo_result_t got;
        if (!rst_n)
        begin
            radius_setting = 8'd50;
            x_sum          = 0;
            y_sum          = 0;
            expected_positions.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radius_setting = wheel_radius;
            if (in_valid && in_ready)
            begin
                dead_reckon(wheels_ready, wheel_turn_1, wheel_turn_2, wheel_turn_3,
                            heading, want);
                expected_positions.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                got = '{x_position, y_position, updated};
                results_seen++;
                if (expected_positions.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result at %0t: x %0d y %0d updated %0b",
                                 $time, got.x, got.y, got.upd);
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (want.upd)
                        updates_seen++;
                    if (want.x == POS_MAX || want.x == POS_MIN ||
                        want.y == POS_MAX || want.y == POS_MIN)
                        limit_hits++;
                    if (got.x !== want.x || got.y !== want.y || got.upd !== want.upd)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"mismatch at %0t: x exp %0d got %0d, ",
                                      "y exp %0d got %0d, updated exp %0b got %0b"},
                                     $time, want.x, got.x, want.y, got.y,
                                     want.upd, got.upd);
                    end
                end
            end
            pending <= expected_positions.size();
        end
    end

endmodule

>>> dv/testbench.sv
// testbench: drives requests, radius writes and result back-pressure into
// omni3_wheel_odometry and gives the verdict. Uses odometry_checker.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIG_BITS   = 15;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 380;
    localparam int SAT_ITEMS   = 16400;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         wheel_radius;
    logic               in_valid;
    logic               in_ready;
    logic               wheels_ready;
    logic signed [15:0] wheel_turn_1;
    logic signed [15:0] wheel_turn_2;
    logic signed [15:0] wheel_turn_3;
    logic signed [14:0] heading;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] x_position;
    logic signed [31:0] y_position;
    logic               updated;

    int fail_count;
    int pending;
    int results_seen;
    int updates_seen;
    int limit_hits;
    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_phase;
    int requests_sent;

    omni3_wheel_odometry #(
        .TRIG_FRAC_BITS(TRIG_BITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .wheel_radius(wheel_radius),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .wheels_ready(wheels_ready),
        .wheel_turn_1(wheel_turn_1),
        .wheel_turn_2(wheel_turn_2),
        .wheel_turn_3(wheel_turn_3),
        .heading     (heading),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .x_position  (x_position),
        .y_position  (y_position),
        .updated     (updated)
    );

    odometry_checker #(
        .TRIG_FRAC_BITS(TRIG_BITS)
    ) odo_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .wheel_radius(wheel_radius),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .wheels_ready(wheels_ready),
        .wheel_turn_1(wheel_turn_1),
        .wheel_turn_2(wheel_turn_2),
        .wheel_turn_3(wheel_turn_3),
        .heading     (heading),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .x_position  (x_position),
        .y_position  (y_position),
        .updated     (updated),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen),
        .updates_seen(updates_seen),
        .limit_hits  (limit_hits)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bound the run: the slow saturation stretch dominates
    initial
    begin
        #90_000_000;
        $display("omni3_wheel_odometry verification failed");
        $finish;
    end

    // Drive result back-pressure; hold off once for a long stretch on request
    initial
    begin : receiver
        bit held;
        held      = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_phase && !held)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (!hold_phase)
                    held = 1'b0;
                out_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Offer one request after a random idle gap and hold it until accepted
    task automatic send_request(input logic ready_in, input logic [15:0] t1,
                                input logic [15:0] t2, input logic [15:0] t3,
                                input logic [14:0] hdg);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        wheels_ready <= ready_in;
        wheel_turn_1 <= t1;
        wheel_turn_2 <= t2;
        wheel_turn_3 <= t3;
        heading      <= hdg;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    // Mix of full-range, corner and small wheel angle changes
    function automatic logic [15:0] random_turn();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(1023) - 512);
            2:
            begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'($urandom_range(8191) - 4096);
        endcase
    endfunction

    task automatic send_random_request();
        logic        rdy;
        logic [14:0] hdg;
        rdy = ($urandom_range(99) < 85);
        if ($urandom_range(9) < 7)
            hdg = 15'($urandom_range(23040) - 11520);
        else
            hdg = 15'($urandom);
        send_request(rdy, random_turn(), random_turn(), random_turn(), hdg);
    endtask

    // Stop offering and wait until every expected result has arrived
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Write the radius only once the block is idle
    task automatic write_radius(input logic [7:0] r);
        drain();
        cfg_valid    <= 1'b1;
        wheel_radius <= r;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n              = 1'b0;
        cfg_valid          = 1'b0;
        wheel_radius       = 8'd50;
        in_valid           = 1'b0;
        wheels_ready       = 1'b0;
        wheel_turn_1       = '0;
        wheel_turn_2       = '0;
        wheel_turn_3       = '0;
        heading            = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_phase         = 1'b0;
        requests_sent      = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset radius, not-ready items, zero move, field extremes,
        // quadrant boundaries and headings beyond half a turn
        send_request(1'b0, 16'd1000, -16'sd2000, 16'd300, 15'd0);
        send_request(1'b1, 16'd0, 16'd0, 16'd0, 15'd0);
        send_request(1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd0);
        send_request(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 15'd0);
        send_request(1'b1, 16'h8000, 16'h7FFF, 16'h0000, 15'd5760);
        send_request(1'b1, 16'h7FFF, 16'h8000, 16'h8000, 15'd11520);
        send_request(1'b1, 16'h8000, 16'h8000, 16'h7FFF, -15'sd11520);
        send_request(1'b1, 16'd1234, -16'sd777, 16'd4000, -15'sd5760);
        send_request(1'b1, 16'd300, 16'd200, -16'sd100, 15'd5759);
        send_request(1'b1, -16'sd300, 16'd2000, 16'd50, 15'd11519);
        send_request(1'b1, 16'd2000, 16'd1000, -16'sd3000, 15'h4000);
        send_request(1'b1, -16'sd5000, 16'd1500, 16'd2500, 15'h3FFF);
        send_request(1'b1, 16'd100, -16'sd100, 16'd0, 15'd1);
        send_request(1'b1, 16'd100, 16'd100, 16'd50, -15'sd1);
        send_request(1'b1, 16'd16, 16'd16, 16'd16, 15'd2880);
        send_request(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 15'h3FFF);
        send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'h0001, -15'sd5761);

        // Zero radius: every move must vanish
        write_radius(8'd0);
        send_request(1'b1, 16'h7FFF, 16'h8000, 16'h8000, 15'd1000);
        send_request(1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, -15'sd3000);
        send_request(1'b0, 16'h1234, 16'h4321, 16'h8000, 15'h5555);

        write_radius(8'd255);
        send_request(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 15'd0);
        send_request(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 15'h4000);

        // Random phases, each with its own radius and idle pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    write_radius(8'd255);
                end
                1:
                begin
                    sender_idle_pct    = 57;
                    receiver_stall_pct = 0;
                    write_radius(8'd1);
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 57;
                    write_radius(8'($urandom_range(254, 2)));
                end
                default:
                begin
                    sender_idle_pct    = 25;
                    receiver_stall_pct = 25;
                    write_radius(8'($urandom));
                end
            endcase
            repeat (PHASE_ITEMS) send_random_request();
        end

        // Long receiver hold-off while requests keep coming
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        write_radius(8'($urandom));
        hold_phase = 1'b1;
        repeat (60) send_random_request();
        drain();
        hold_phase = 1'b0;

        // Drive x up and y down at full speed until both totals clamp,
        // then step back off the limits with random moves
        write_radius(8'd255);
        repeat (SAT_ITEMS)
            send_request(1'b1, 16'(32767 - $urandom_range(60)),
                         16'(32767 - $urandom_range(60)),
                         16'(-32768 + $urandom_range(60)),
                         15'(-2880 + $urandom_range(128) - 64));
        repeat (40) send_random_request();

        // Let any stray result show up before the verdict
        drain();
        repeat (300) @(posedge clk);

        $display("Sent %0d requests over eight radius settings and four idle patterns.",
                 requests_sent);
        $display("Checked %0d results: %0d moved the totals, %0d sat at a total limit.",
                 results_seen, updates_seen, limit_hits);
        if (fail_count == 0 && pending == 0)
            $display("omni3_wheel_odometry verification clean");
        else
            $display("omni3_wheel_odometry verification failed");
        $finish;
    end

endmodule

>>> omni3_wheel_odometry.f
rtl/o3wo_pkg.sv
rtl/omni3_wheel_odometry.sv
dv/odometry_checker.sv
dv/testbench.sv
